### hw/rtl/mbrot_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
// Used by mbrot_cell, mandelbrot_escape_time and the bench; depends on nothing else.
package mbrot_pkg;

	localparam int Z_W      = 32;               // Q4.28 coordinate width
	localparam int PROD_W   = 64;               // exact product width, Q.56
	localparam int NEXT_W   = 38;               // width of an update before range check
	localparam int FRAC_W   = 28;               // fraction bits of z and c
	localparam int CNT_OUT_W = 7;               // width of the reported count
	localparam int LIMIT_W  = 7;                // width of the limit register

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// Escape radius squared, 4.0 in Q.56.
	localparam logic [PROD_W-1:0] FOUR_Q56 = 64'h0400_0000_0000_0000;

	// A component at or beyond 8.0 in magnitude escapes without squaring.
	localparam logic signed [NEXT_W-1:0] BIG_Q28 = 38'sd2147483648;

	// One point as it moves along the cell chain.
	typedef struct packed {
		logic signed [Z_W-1:0] c_re;
		logic signed [Z_W-1:0] c_im;
		logic signed [Z_W-1:0] z_re;
		logic signed [Z_W-1:0] z_im;
		logic                  done;   // result settled in an earlier cell
		logic                  esc;    // escaped flag of a settled result
		logic                  pend;   // z is an update whose magnitude is not yet tested
	} point_tok_t;

endpackage

### hw/rtl/mbrot_cell.sv
// One iteration cell of the escape-time chain: a multiply stage, then the
// magnitude test of the previous update and the next update of z.
// Depends on mbrot_pkg.
module mbrot_cell #(
	parameter int CELL_INDEX = 0,
	parameter int CNT_W      = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic [CNT_W-1:0]        lim,
	input  logic                    in_valid,
	input  mbrot_pkg::point_tok_t   in_tok,
	input  logic [CNT_W-1:0]        in_cnt,
	output logic                    out_valid,
	output mbrot_pkg::point_tok_t   out_tok,
	output logic [CNT_W-1:0]        out_cnt
);

	localparam logic [CNT_W-1:0] K_IDX  = CNT_W'(CELL_INDEX);
	localparam logic [CNT_W-1:0] K_PREV = CNT_W'((CELL_INDEX > 0) ? CELL_INDEX - 1 : 0);

	logic                                      v_s1;
	mbrot_pkg::point_tok_t                     tok_s1;
	logic [CNT_W-1:0]                          cnt_s1;
	logic signed [mbrot_pkg::PROD_W-1:0]       rr_s1;
	logic signed [mbrot_pkg::PROD_W-1:0]       ii_s1;
	logic signed [mbrot_pkg::PROD_W-1:0]       ri_s1;

	logic                                      v_s2;
	mbrot_pkg::point_tok_t                     tok_s2;
	logic [CNT_W-1:0]                          cnt_s2;

	logic signed [mbrot_pkg::PROD_W-1:0]       rr;
	logic signed [mbrot_pkg::PROD_W-1:0]       ii;
	logic signed [mbrot_pkg::PROD_W-1:0]       ri;
	logic [mbrot_pkg::PROD_W-1:0]              mag_sq;
	logic signed [mbrot_pkg::PROD_W-1:0]       diff;
	logic signed [mbrot_pkg::NEXT_W-1:0]       nre;
	logic signed [mbrot_pkg::NEXT_W-1:0]       nim;
	logic                                      over;
	logic                                      huge;
	mbrot_pkg::point_tok_t                     tok_nx;
	logic [CNT_W-1:0]                          cnt_nx;

	assign rr = in_tok.z_re * in_tok.z_re;
	assign ii = in_tok.z_im * in_tok.z_im;
	assign ri = in_tok.z_re * in_tok.z_im;

	// Both squares are nonnegative and at most 2^62, so the sum cannot wrap.
	assign mag_sq = $unsigned(rr_s1) + $unsigned(ii_s1);
	assign over   = mag_sq > mbrot_pkg::FOUR_Q56;
	assign diff   = rr_s1 - ii_s1;

	// Arithmetic shifts give the floor; the doubling of re*im folds into the shift.
	assign nre = mbrot_pkg::NEXT_W'(diff >>> mbrot_pkg::FRAC_W)
		+ mbrot_pkg::NEXT_W'(tok_s1.c_re);
	assign nim = mbrot_pkg::NEXT_W'(ri_s1 >>> (mbrot_pkg::FRAC_W - 1))
		+ mbrot_pkg::NEXT_W'(tok_s1.c_im);
	assign huge = (nre >= mbrot_pkg::BIG_Q28) || (nre <= -mbrot_pkg::BIG_Q28)
		|| (nim >= mbrot_pkg::BIG_Q28) || (nim <= -mbrot_pkg::BIG_Q28);

	always_comb begin
		tok_nx = tok_s1;
		cnt_nx = cnt_s1;
		if (!tok_s1.done) begin
			priority if (tok_s1.pend && over) begin
				tok_nx.done = 1'b1;
				tok_nx.esc  = 1'b1;
				tok_nx.pend = 1'b0;
				cnt_nx      = K_PREV;
			end else if (K_IDX < lim) begin
				if (huge) begin
					tok_nx.done = 1'b1;
					tok_nx.esc  = 1'b1;
					tok_nx.pend = 1'b0;
					cnt_nx      = K_IDX;
				end else begin
					tok_nx.z_re = mbrot_pkg::Z_W'(nre);
					tok_nx.z_im = mbrot_pkg::Z_W'(nim);
					tok_nx.pend = 1'b1;
				end
			end else begin
				// The limit is reached without escape.
				tok_nx.done = 1'b1;
				tok_nx.esc  = 1'b0;
				tok_nx.pend = 1'b0;
				cnt_nx      = lim;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1 <= in_tok;
			cnt_s1 <= in_cnt;
			rr_s1  <= rr;
			ii_s1  <= ii;
			ri_s1  <= ri;
			tok_s2 <= tok_nx;
			cnt_s2 <= cnt_nx;
		end
	end

	assign out_valid = v_s2;
	assign out_tok   = tok_s2;
	assign out_cnt   = cnt_s2;

endmodule

### hw/rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time block: limit register, cell chain
// and stream ports. Depends on mbrot_pkg and mbrot_cell.
//
// Usage:
//   s_axis carries one point per transfer, tdata = {point_imag, point_real},
//   both signed Q4.28. m_axis returns one result per point in input order:
//   tdata holds iteration_count in bits 6:0, tuser holds escaped.
//   cfg_valid/cfg_data write the iteration limit; cfg_ready is always high.
//   Write it only while no point is in flight.
// Structure:
//   The chain has MAX_ITERATIONS + 1 cells of two register stages each, one
//   cell per possible iteration plus a final magnitude test; every point
//   passes all cells, whatever its count. A new point is taken every cycle
//   unless the receiver stalls; the three 32x32 multipliers in each cell
//   set the clock rate.
// Reset clears the pipeline and sets the limit to 64.
// When the receiver stalls, the whole chain holds and s_axis_tready falls
// in the same cycle; no point is dropped.
module mandelbrot_escape_time #(
	parameter int MAX_ITERATIONS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // point_real [31:0], point_imag [63:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // iteration_count [6:0], zero [7]
	output logic        m_axis_tuser,   // escaped [0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data        // iteration_limit [6:0]
);

	localparam int CNT_W = ($clog2(MAX_ITERATIONS + 1) > mbrot_pkg::CNT_OUT_W)
		? $clog2(MAX_ITERATIONS + 1) : mbrot_pkg::CNT_OUT_W;
	localparam int N_CELLS = MAX_ITERATIONS + 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITERATIONS);

	logic [mbrot_pkg::LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]              lim;
	logic                          adv;

	logic                          chain_valid [0:N_CELLS];
	mbrot_pkg::point_tok_t         chain_tok   [0:N_CELLS];
	logic [CNT_W-1:0]              chain_cnt   [0:N_CELLS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mbrot_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign lim = (CNT_W'(limit_q) > MAX_CNT) ? MAX_CNT : CNT_W'(limit_q);

	// The last cell's second stage doubles as the output register.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	assign chain_valid[0]    = s_axis_tvalid;
	assign chain_tok[0].c_re = s_axis_tdata[31:0];
	assign chain_tok[0].c_im = s_axis_tdata[63:32];
	assign chain_tok[0].z_re = s_axis_tdata[31:0];
	assign chain_tok[0].z_im = s_axis_tdata[63:32];
	assign chain_tok[0].done = 1'b0;
	assign chain_tok[0].esc  = 1'b0;
	assign chain_tok[0].pend = 1'b0;
	assign chain_cnt[0]      = '0;

	for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
		mbrot_cell #(
			.CELL_INDEX (k),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.lim       (lim),
			.in_valid  (chain_valid[k]),
			.in_tok    (chain_tok[k]),
			.in_cnt    (chain_cnt[k]),
			.out_valid (chain_valid[k+1]),
			.out_tok   (chain_tok[k+1]),
			.out_cnt   (chain_cnt[k+1])
		);
	end

	assign m_axis_tvalid = chain_valid[N_CELLS];
	assign m_axis_tdata  = {1'b0, chain_cnt[N_CELLS][mbrot_pkg::CNT_OUT_W-1:0]};
	assign m_axis_tuser  = chain_tok[N_CELLS].esc;

`ifndef ASSERT_OFF
	a_result_settled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> chain_tok[N_CELLS].done && !chain_tok[N_CELLS].pend)
		else $error("result left the chain unsettled");

	a_escape_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> chain_cnt[N_CELLS] < lim)
		else $error("escaped point reports a count at or above the limit");

	a_inside_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> chain_cnt[N_CELLS] == lim)
		else $error("point inside the set does not report the limit");

	a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain_cnt[N_CELLS]) && $stable(chain_tok[N_CELLS]))
		else $error("chain moved during a stall");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for mandelbrot_escape_time: streams complex points
// through the block and compares each escape count against an in-bench orbit
// tracer. Depends on mbrot_pkg and the RTL of the block only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITER_CAP   = 64;
	localparam int CHAIN_LAT  = 2 * (ITER_CAP + 1);
	localparam int PHASE_PTS  = 105;
	localparam longint ONE_Q  = 64'sd1 << mbrot_pkg::FRAC_W;

	typedef struct {
		logic [mbrot_pkg::CNT_OUT_W-1:0] count;
		logic                            esc;
	} escape_result_t;

	class escape_scoreboard;
		int unsigned limit_reg;
		escape_result_t expected_escapes[$];
		int errors;
		int points_seen;
		int escaped_seen;
		int inside_seen;

		function new();
			limit_reg = mbrot_pkg::LIMIT_RESET;
		endfunction

		function void set_limit(logic [mbrot_pkg::LIMIT_W-1:0] value);
			limit_reg = value;
		endfunction

		function int pending();
			return expected_escapes.size();
		endfunction

		// Iterates z = z*z + c in exact Q.28/Q.56 fixed point.
		function escape_result_t trace_orbit(logic signed [mbrot_pkg::Z_W-1:0] c_re32,
				logic signed [mbrot_pkg::Z_W-1:0] c_im32);
			longint c_re, c_im, zr, zi, nr, ni, limit, big;
			escape_result_t r;
			c_re = c_re32;
			c_im = c_im32;
			zr = c_re;
			zi = c_im;
			big = 64'sd1 << 31;
			limit = (limit_reg > ITER_CAP) ? ITER_CAP : limit_reg;
			r.count = limit[mbrot_pkg::CNT_OUT_W-1:0];
			r.esc = 1'b0;
			for (int n = 0; n < limit; n++) begin
				nr = ((zr * zr - zi * zi) >>> mbrot_pkg::FRAC_W) + c_re;
				ni = ((zr * zi) >>> (mbrot_pkg::FRAC_W - 1)) + c_im;
				zr = nr;
				zi = ni;
				// Components of magnitude 8 or more escape before any squaring.
				if (zr >= big || zr <= -big || zi >= big || zi <= -big ||
						zr * zr + zi * zi > (64'sd1 << 58)) begin
					r.count = n[mbrot_pkg::CNT_OUT_W-1:0];
					r.esc = 1'b1;
					return r;
				end
			end
			return r;
		endfunction

		function void note_point(logic signed [mbrot_pkg::Z_W-1:0] re,
				logic signed [mbrot_pkg::Z_W-1:0] im);
			expected_escapes.push_back(trace_orbit(re, im));
			points_seen++;
		endfunction

		function void check_result(logic [7:0] tdata, logic tuser);
			escape_result_t want;
			if (expected_escapes.size() == 0) begin
				$display("%0t: result with nothing outstanding: count %0d escaped %0b",
					$realtime, tdata, tuser);
				errors++;
				return;
			end
			want = expected_escapes.pop_front();
			if (tdata !== {1'b0, want.count}) begin
				$display("%0t: iteration_count expected %0d, got %0d (tdata %h)",
					$realtime, want.count, tdata[6:0], tdata);
				errors++;
			end
			if (tuser !== want.esc) begin
				$display("%0t: escaped expected %0b, got %0b", $realtime, want.esc, tuser);
				errors++;
			end
			if (want.esc)
				escaped_seen++;
			else
				inside_seen++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	escape_scoreboard sb = new();
	int burst_left = 1;
	int limits_used = 1;
	int unsigned ready_cyc = 0;
	int unsigned ready_mode = 0;

	mandelbrot_escape_time #(.MAX_ITERATIONS(ITER_CAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver backpressure: the stall style is redrawn at random among four.
	always @(negedge clk) begin
		ready_cyc <= ready_cyc + 1;
		if (ready_cyc % 200 == 0)
			ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= (ready_cyc % 3 != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= (ready_cyc[4:0] >= 12);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic push_point(input logic [31:0] re, input logic [31:0] im);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {im, re};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		sb.note_point(re, im);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
	endtask

	task automatic push_random_point();
		logic [31:0] re, im;
		case ($urandom_range(0, 7))
			0, 1: begin
				re = $urandom();
				im = $urandom();
			end
			2: begin
				// Near the boundary of the main cardioid and the period-two bulb.
				re = 32'(-(ONE_Q * 3 / 4) + longint'($urandom_range(0, 2 * 16777216)) - 16777216);
				im = 32'(longint'($urandom_range(0, 2 * 33554432)) - 33554432);
			end
			default: begin
				// Region from -2.5 to 1.0 real and -1.5 to 1.5 imaginary.
				re = 32'(longint'($urandom_range(0, 939524096)) - 671088640);
				im = 32'(longint'($urandom_range(0, 805306368)) - 402653184);
			end
		endcase
		push_point(re, im);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_limit(input logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		sb.set_limit(value);
		limits_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [6:0] limit_plan[8];
		limit_plan = '{7'd1, 7'd127, 7'd0, 7'd65, 7'd2, 7'd0, 7'd64, 7'd0};
		limit_plan[5] = $urandom_range(3, 63);
		limit_plan[7] = $urandom_range(1, 127);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points at the reset limit.
		push_point(32'h0000_0000, 32'h0000_0000);   // origin, never escapes
		push_point(32'h8000_0000, 32'h8000_0000);   // most negative corner
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // most positive corner
		push_point(32'h8000_0000, 32'h7FFF_FFFF);
		push_point(32'h7FFF_FFFF, 32'h8000_0000);
		push_point(32'h8000_0000, 32'h0000_0000);   // -8 real, huge intermediate
		push_point(32'h0000_0000, 32'h8000_0000);
		push_point(32'hE000_0000, 32'h0000_0000);   // -2 sits on |z|^2 == 4 forever
		push_point(32'h2000_0000, 32'h0000_0000);   // +2 escapes at once
		push_point(32'h0400_0000, 32'h0000_0000);   // 0.25, slow convergence
		push_point(32'h0400_0001, 32'h0000_0000);   // just past 0.25, late escape
		push_point(32'hF000_0000, 32'h0000_0000);   // -1, period two
		push_point(32'h0000_0000, 32'h1000_0000);   // i, bounded
		push_point(32'h0000_0000, 32'hF000_0000);   // -i
		push_point(32'h0800_0000, 32'h0800_0000);   // 0.5 + 0.5i
		push_point(32'hFFFF_FFFF, 32'h0000_0001);   // smallest nonzero magnitudes
		push_point(32'h0000_0001, 32'hFFFF_FFFF);
		push_point(32'hF400_0000, 32'h01A0_0000);   // near the cardioid neck
		push_point(32'h1C00_0000, 32'h1C00_0000);
		push_point(32'h5555_5555, 32'hAAAA_AAAA);
		repeat (PHASE_PTS - 20) push_random_point();
		wait_drained();

		foreach (limit_plan[i]) begin
			write_limit(limit_plan[i]);
			if (i == 3)
				burst_left = 1000;   // no sender gaps for the rest of the run
			repeat (PHASE_PTS) push_random_point();
			wait_drained();
		end

		repeat (CHAIN_LAT + 20) @(negedge clk);
		$display("Checked %0d points under %0d limit settings (0, 1, 2, 64, 65, 127 among them).",
			sb.points_seen, limits_used);
		$display("%0d points escaped, %0d stayed inside; %0d still outstanding.",
			sb.escaped_seen, sb.inside_seen, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", sb.pending());
		$display("end of test: mismatches");
		$finish;
	end
endmodule
